### rtl/core/sli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_pkg
// Shared constants, codes and controller/datapath interface types of the
// sorted list insert block.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 6;
   localparam int CNT_W    = 7;
   localparam int KIND_W   = 2;
   localparam int STAT_W   = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_INSERT = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_UNSORTED = 2'd2,
      ST_RANGE    = 2'd3
   } rsp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_READ_WAIT,
      S_APP_WAIT,
      S_INS_CMP,
      S_SCAN_FIRST,
      S_SCAN_STEP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_CFG,
      OP_SCAN_PRIME,
      OP_SCAN_CMP,
      OP_CLEAR_RSP,
      OP_REFUSE,
      OP_READ_ISSUE,
      OP_READ_RSP,
      OP_APP_ISSUE,
      OP_APP_WRITE,
      OP_INS_START,
      OP_INS_SHIFT,
      OP_INS_PLACE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     in_range;
      logic     order_ok;
      logic     move;
      logic     ptr_zero;
      logic     scan_more;
      logic     scan_last;
   } dp_stat_type;

endpackage
`default_nettype wire

### rtl/core/sli_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_ctrl
// Controller: sequences each request and each order rescan over the datapath.
// ----------------------------------------------------------------------------
module sli_ctrl
   import sli_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        csr_valid,
   input  wire dp_stat_type stat,
   output logic             busy,
   output logic             csr_ready,
   output dp_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      busy      = (state_ff != S_IDLE);
      csr_ready = (state_ff == S_IDLE) && !start;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECODE;
            end else if (csr_valid) begin
               cmd.op   = OP_CFG;
               state_in = S_SCAN_FIRST;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (stat.kind)
               KIND_CLEAR: cmd.op = OP_CLEAR_RSP;
               KIND_READ: begin
                  if (stat.in_range) begin
                     cmd.op   = OP_READ_ISSUE;
                     state_in = S_READ_WAIT;
                  end else begin
                     cmd.op = OP_REFUSE;
                  end
               end
               KIND_APPEND: begin
                  if (stat.full) begin
                     cmd.op = OP_REFUSE;
                  end else begin
                     cmd.op   = OP_APP_ISSUE;
                     state_in = S_APP_WAIT;
                  end
               end
               KIND_INSERT: begin
                  if (stat.full || !stat.order_ok) begin
                     cmd.op = OP_REFUSE;
                  end else begin
                     cmd.op   = OP_INS_START;
                     state_in = S_INS_CMP;
                  end
               end
               default: cmd.op = OP_REFUSE;
            endcase
         end
         S_READ_WAIT: begin
            cmd.op   = OP_READ_RSP;
            state_in = S_IDLE;
         end
         S_APP_WAIT: begin
            cmd.op   = OP_APP_WRITE;
            state_in = S_IDLE;
         end
         S_INS_CMP: begin
            if (stat.ptr_zero || !stat.move) begin
               cmd.op   = OP_INS_PLACE;
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_INS_SHIFT;
            end
         end
         S_SCAN_FIRST: begin
            if (stat.scan_more) begin
               cmd.op   = OP_SCAN_PRIME;
               state_in = S_SCAN_STEP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN_STEP: begin
            cmd.op = OP_SCAN_CMP;
            if (stat.scan_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/sli_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sli_datapath
// Datapath: entry memory, count, order flag, shift pointer and result
// registers.
// ----------------------------------------------------------------------------
module sli_datapath
   import sli_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   input  wire logic [KIND_W-1:0]  req_kind,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic [POS_W-1:0]   req_index,
   input  wire logic               csr_descending,
   output dp_stat_type             stat,
   output logic                    rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [POS_W-1:0]        rsp_position,
   output logic [CNT_W-1:0]        rsp_count,
   output logic                    rsp_in_order,
   output logic [STAT_W-1:0]       rsp_status
);

   function automatic logic fits_after(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b,
                                       input logic desc);
      fits_after = desc ? (b <= a) : (b >= a);
   endfunction

   logic signed [DATA_W-1:0] entry_mem [CAPACITY];

   kind_type                 kind_ff,  kind_in;
   logic signed [DATA_W-1:0] val_ff,   val_in;
   logic [POS_W-1:0]         idx_ff,   idx_in;
   logic [CNT_W-1:0]         cnt_ff,   cnt_in;
   logic                     order_ff, order_in;
   logic                     desc_ff,  desc_in;
   logic [IDX_W-1:0]         ptr_ff,   ptr_in;
   logic signed [DATA_W-1:0] prev_ff,  prev_in;
   logic signed [DATA_W-1:0] rdata_ff;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic signed [DATA_W-1:0] rsp_data_ff,   rsp_data_in;
   logic [POS_W-1:0]         rsp_pos_ff,    rsp_pos_in;
   logic [CNT_W-1:0]         rsp_cnt_ff,    rsp_cnt_in;
   logic                     rsp_order_ff,  rsp_order_in;
   rsp_status_type           rsp_stat_ff,   rsp_stat_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic [IDX_W-1:0]         rd_addr;
   logic [CNT_W-1:0]         cnt_m1;
   logic [CNT_W-1:0]         cnt_p1;
   logic                     app_order;

   assign cnt_m1 = cnt_ff - CNT_W'(1);
   assign cnt_p1 = cnt_ff + CNT_W'(1);
   assign app_order = order_ff && ((cnt_ff == '0) || fits_after(rdata_ff, val_ff, desc_ff));

   always_comb begin
      stat.kind      = kind_ff;
      stat.full      = (cnt_ff >= CNT_W'(CAPACITY));
      stat.in_range  = ({1'b0, idx_ff} < cnt_ff);
      stat.order_ok  = order_ff;
      stat.move      = desc_ff ? (val_ff > rdata_ff) : (val_ff < rdata_ff);
      stat.ptr_zero  = (ptr_ff == '0);
      stat.scan_more = (cnt_ff > CNT_W'(1));
      stat.scan_last = (CNT_W'(ptr_ff) == cnt_m1);
   end

   always_comb begin
      kind_in       = kind_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      order_in      = order_ff;
      desc_in       = desc_ff;
      ptr_in        = ptr_ff;
      prev_in       = prev_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_order_in  = rsp_order_ff;
      rsp_stat_in   = rsp_stat_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = val_ff;
      rd_addr       = ptr_ff;
      case (cmd.op)
         OP_LATCH: begin
            kind_in = kind_type'(req_kind);
            val_in  = req_value;
            idx_in  = req_index;
         end
         OP_CFG: begin
            desc_in  = csr_descending;
            order_in = 1'b1;
            rd_addr  = '0;
         end
         OP_SCAN_PRIME: begin
            prev_in = rdata_ff;
            ptr_in  = IDX_W'(1);
            rd_addr = IDX_W'(1);
         end
         OP_SCAN_CMP: begin
            if (!fits_after(prev_ff, rdata_ff, desc_ff)) begin
               order_in = 1'b0;
            end
            prev_in = rdata_ff;
            ptr_in  = ptr_ff + IDX_W'(1);
            rd_addr = ptr_ff + IDX_W'(1);
         end
         OP_CLEAR_RSP: begin
            cnt_in        = '0;
            order_in      = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '0;
            rsp_pos_in    = '0;
            rsp_cnt_in    = '0;
            rsp_order_in  = 1'b1;
            rsp_stat_in   = ST_OK;
         end
         OP_REFUSE: begin
            rsp_strobe_in = 1'b1;
            rsp_cnt_in    = cnt_ff;
            rsp_order_in  = order_ff;
            if (kind_ff == KIND_READ) begin
               rsp_data_in = '0;
               rsp_pos_in  = idx_ff;
               rsp_stat_in = ST_RANGE;
            end else begin
               rsp_data_in = val_ff;
               rsp_pos_in  = '0;
               rsp_stat_in = stat.full ? ST_FULL : ST_UNSORTED;
            end
         end
         OP_READ_ISSUE: begin
            rd_addr = idx_ff[IDX_W-1:0];
         end
         OP_READ_RSP: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = rdata_ff;
            rsp_pos_in    = idx_ff;
            rsp_cnt_in    = cnt_ff;
            rsp_order_in  = order_ff;
            rsp_stat_in   = ST_OK;
         end
         OP_APP_ISSUE: begin
            rd_addr = cnt_m1[IDX_W-1:0];
         end
         OP_APP_WRITE: begin
            wr_en         = 1'b1;
            wr_addr       = cnt_ff[IDX_W-1:0];
            order_in      = app_order;
            cnt_in        = cnt_p1;
            rsp_strobe_in = 1'b1;
            rsp_data_in   = val_ff;
            rsp_pos_in    = POS_W'(cnt_ff[IDX_W-1:0]);
            rsp_cnt_in    = cnt_p1;
            rsp_order_in  = app_order;
            rsp_stat_in   = ST_OK;
         end
         OP_INS_START: begin
            ptr_in  = cnt_ff[IDX_W-1:0];
            rd_addr = cnt_m1[IDX_W-1:0];
         end
         OP_INS_SHIFT: begin
            wr_en   = 1'b1;
            wr_data = rdata_ff;
            ptr_in  = ptr_ff - IDX_W'(1);
            rd_addr = ptr_ff - IDX_W'(2);
         end
         OP_INS_PLACE: begin
            wr_en         = 1'b1;
            cnt_in        = cnt_p1;
            rsp_strobe_in = 1'b1;
            rsp_data_in   = val_ff;
            rsp_pos_in    = POS_W'(ptr_ff);
            rsp_cnt_in    = cnt_p1;
            rsp_order_in  = order_ff;
            rsp_stat_in   = ST_OK;
         end
         default: begin
            rd_addr = ptr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         order_ff      <= 1'b1;
         desc_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         order_ff      <= order_in;
         desc_ff       <= desc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      val_ff       <= val_in;
      idx_ff       <= idx_in;
      ptr_ff       <= ptr_in;
      prev_ff      <= prev_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_order_ff <= rsp_order_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_count    = rsp_cnt_ff;
   assign rsp_in_order = rsp_order_ff;
   assign rsp_status   = rsp_stat_ff;

endmodule
`default_nettype wire

### rtl/core/sorted_list_insert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert
// Ordered list of signed 32-bit values with clear, append, sorted insert and
// read requests, and a selectable ascending or descending order.
// ----------------------------------------------------------------------------
// Clear and refused requests answer from the decode step. Read and append
// first read the entry memory. A sorted insert moves up each entry that must
// make room, one compare and one move a cycle through the entry memory.
// busy falls in the strobe cycle, so a new request is taken at its end edge.
// Writing csr_descending rescans the stored entries while busy is high;
// the compare steps are skipped when fewer than two entries are held.
// Reset empties the list, selects ascending order and sets in_order; the
// entry memory is not cleared. The result is not held off by the receiver.
module sorted_list_insert
   import sli_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [KIND_W-1:0]        req_kind,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic [POS_W-1:0]         req_index,
   output logic                          rsp_strobe,
   output logic signed [DATA_W-1:0]      rsp_data,
   output logic [POS_W-1:0]              rsp_position,
   output logic [CNT_W-1:0]              rsp_count,
   output logic                          rsp_in_order,
   output logic [STAT_W-1:0]             rsp_status,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic                     csr_descending
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .stat      (stat),
      .busy      (busy),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   sli_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_index      (req_index),
      .csr_descending (csr_descending),
      .stat           (stat),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .rsp_position   (rsp_position),
      .rsp_count      (rsp_count),
      .rsp_in_order   (rsp_in_order),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_list_insert. A short table of directed
// requests is followed by random bursts of clear, append, sorted insert and
// read requests. The order register is rewritten between some bursts. A shadow
// copy of the list predicts each response that the table does not fix, and
// responses are checked in order as they are strobed out.
// ----------------------------------------------------------------------------
module tb
   import sli_pkg::*;
();

   localparam int RANDOM_ITEMS = 1450;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [POS_W-1:0]         position;
      logic [CNT_W-1:0]         count;
      logic                     in_order;
      rsp_status_type           status;
   } list_rsp_type;

   typedef enum bit [1:0] {
      ROW_REQ,
      ROW_FIXED,
      ROW_CFG
   } plan_kind_type;

   typedef struct packed {
      plan_kind_type            tag;
      kind_type                 op;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         index;
      list_rsp_type             want;
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [KIND_W-1:0]        req_kind;
   logic signed [DATA_W-1:0] req_value;
   logic [POS_W-1:0]         req_index;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_data;
   logic [POS_W-1:0]         rsp_position;
   logic [CNT_W-1:0]         rsp_count;
   logic                     rsp_in_order;
   logic [STAT_W-1:0]        rsp_status;
   logic                     csr_valid;
   logic                     csr_ready;
   logic                     csr_descending;

   logic signed [DATA_W-1:0] shadow_vals [CAPACITY];
   int                       shadow_len;
   bit                       shadow_sorted;
   bit                       shadow_desc;

   list_rsp_type             rsp_due [$];
   list_rsp_type             head_rsp;
   plan_row_type             dir_plan [$];
   plan_row_type             cur_row;
   int                       fault_count = 0;
   int                       idle_pct;
   int                       rnd_sent;
   int                       burst;
   int                       roll;
   int                       j;
   logic [POS_W-1:0]         pick_idx;
   logic signed [DATA_W-1:0] pick_val;

   sorted_list_insert dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .rsp_position   (rsp_position),
      .rsp_count      (rsp_count),
      .rsp_in_order   (rsp_in_order),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_descending (csr_descending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit fits_order(input logic signed [DATA_W-1:0] a, b);
      return shadow_desc ? (b <= a) : (b >= a);
   endfunction

   function automatic list_rsp_type apply_list_op(kind_type op, logic signed [DATA_W-1:0] val,
                                                  logic [POS_W-1:0] idx);
      list_rsp_type r;
      int           slot;
      r.data     = '0;
      r.position = '0;
      r.status   = ST_OK;
      case (op)
         KIND_CLEAR: begin
            shadow_len    = 0;
            shadow_sorted = 1'b1;
         end
         KIND_READ: begin
            r.position = idx;
            if (idx < shadow_len) r.data = shadow_vals[idx];
            else r.status = ST_RANGE;
         end
         default: begin
            r.data = val;
            if (shadow_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (op == KIND_APPEND) begin
               if (shadow_len > 0 && !fits_order(shadow_vals[shadow_len-1], val))
                  shadow_sorted = 1'b0;
               shadow_vals[shadow_len] = val;
               r.position = POS_W'(shadow_len);
               shadow_len++;
            end else if (!shadow_sorted) begin
               r.status = ST_UNSORTED;
            end else begin
               slot = shadow_len;
               while (slot > 0 && !fits_order(shadow_vals[slot-1], val)) begin
                  shadow_vals[slot] = shadow_vals[slot-1];
                  slot--;
               end
               shadow_vals[slot] = val;
               r.position = POS_W'(slot);
               shadow_len++;
            end
         end
      endcase
      r.count    = CNT_W'(shadow_len);
      r.in_order = shadow_sorted;
      return r;
   endfunction

   function automatic list_rsp_type want_rsp(logic signed [DATA_W-1:0] data, int position,
                                             int count, bit in_order, rsp_status_type status);
      list_rsp_type r;
      r.data     = data;
      r.position = POS_W'(position);
      r.count    = CNT_W'(count);
      r.in_order = in_order;
      r.status   = status;
      return r;
   endfunction

   function automatic plan_row_type plan_row(plan_kind_type tag, kind_type op,
                                             logic signed [DATA_W-1:0] value,
                                             logic [POS_W-1:0] index, list_rsp_type want);
      plan_row_type p;
      p.tag   = tag;
      p.op    = op;
      p.value = value;
      p.index = index;
      p.want  = want;
      return p;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3, 4: return $urandom;
         default: return $signed($urandom_range(0, 40)) - 20;
      endcase
   endfunction

   task automatic issue_req(kind_type op, logic signed [DATA_W-1:0] val,
                            logic [POS_W-1:0] idx, bit use_want, list_rsp_type want);
      list_rsp_type calc;
      start     <= 1'b1;
      req_kind  <= op;
      req_value <= val;
      req_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      calc = apply_list_op(op, val, idx);
      rsp_due.push_back(use_want ? want : calc);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic write_order(bit desc);
      int i;
      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_descending <= desc;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      shadow_desc   = desc;
      shadow_sorted = 1'b1;
      for (i = 1; i < shadow_len; i++)
         if (!fits_order(shadow_vals[i-1], shadow_vals[i])) shadow_sorted = 1'b0;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: response with no request pending, data expected none actual %0h",
                     $time, rsp_data);
            fault_count++;
         end else begin
            head_rsp = rsp_due.pop_front();
            check_field("data", head_rsp.data, rsp_data);
            check_field("position", 32'(head_rsp.position), 32'(rsp_position));
            check_field("count", 32'(head_rsp.count), 32'(rsp_count));
            check_field("in_order", 32'(head_rsp.in_order), 32'(rsp_in_order));
            check_field("status", 32'(head_rsp.status), 32'(rsp_status));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("tb: errors");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_kind       <= KIND_CLEAR;
      req_value      <= '0;
      req_index      <= '0;
      csr_valid      <= 1'b0;
      csr_descending <= 1'b0;
      shadow_len     = 0;
      shadow_sorted  = 1'b1;
      shadow_desc    = 1'b0;
      idle_pct       = 27;

      dir_plan.push_back(plan_row(ROW_FIXED, KIND_READ, 0, 0,
                                  want_rsp(0, 0, 0, 1'b1, ST_RANGE)));
      dir_plan.push_back(plan_row(ROW_FIXED, KIND_READ, 0, 63,
                                  want_rsp(0, 63, 0, 1'b1, ST_RANGE)));
      dir_plan.push_back(plan_row(ROW_FIXED, KIND_INSERT, 32'h7fff_ffff, 0,
                                  want_rsp(32'h7fff_ffff, 0, 1, 1'b1, ST_OK)));
      dir_plan.push_back(plan_row(ROW_FIXED, KIND_INSERT, 32'h8000_0000, 0,
                                  want_rsp(32'h8000_0000, 0, 2, 1'b1, ST_OK)));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_INSERT, 0, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_INSERT, 0, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_READ, 0, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_READ, 0, 3, '0));
      dir_plan.push_back(plan_row(ROW_FIXED, KIND_READ, 0, 4,
                                  want_rsp(0, 4, 4, 1'b1, ST_RANGE)));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_APPEND, -1, 0, '0));
      dir_plan.push_back(plan_row(ROW_FIXED, KIND_INSERT, 5, 0,
                                  want_rsp(5, 0, 5, 1'b0, ST_UNSORTED)));
      dir_plan.push_back(plan_row(ROW_FIXED, KIND_CLEAR, 0, 0,
                                  want_rsp(0, 0, 0, 1'b1, ST_OK)));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_INSERT, 10, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_INSERT, 30, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_INSERT, 20, 0, '0));
      dir_plan.push_back(plan_row(ROW_CFG, KIND_CLEAR, 1, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_INSERT, 7, 0, '0));
      dir_plan.push_back(plan_row(ROW_FIXED, KIND_CLEAR, 0, 0,
                                  want_rsp(0, 0, 0, 1'b1, ST_OK)));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_INSERT, -5, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_INSERT, 100, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_INSERT, -5, 0, '0));
      dir_plan.push_back(plan_row(ROW_CFG, KIND_CLEAR, 0, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_READ, 0, 1, '0));
      dir_plan.push_back(plan_row(ROW_CFG, KIND_CLEAR, 1, 0, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_READ, 0, 2, '0));
      dir_plan.push_back(plan_row(ROW_REQ, KIND_APPEND, 200, 0, '0));
      dir_plan.push_back(plan_row(ROW_FIXED, KIND_CLEAR, 0, 0,
                                  want_rsp(0, 0, 0, 1'b1, ST_OK)));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_plan[k]) begin
         cur_row = dir_plan[k];
         if (cur_row.tag == ROW_CFG) write_order(cur_row.value[0]);
         else issue_req(cur_row.op, cur_row.value, cur_row.index,
                        cur_row.tag == ROW_FIXED, cur_row.want);
      end

      // bursts that mostly grow an ordered list, with some noise
      rnd_sent = 0;
      while (rnd_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 50) write_order(1'($urandom_range(0, 1)));
         if ($urandom_range(0, 99) < 75) begin
            issue_req(KIND_CLEAR, $urandom, POS_W'($urandom_range(0, 63)), 1'b0, '0);
            rnd_sent++;
         end
         burst = $urandom_range(1, 100);
         for (j = 0; j < burst && rnd_sent < RANDOM_ITEMS; j++) begin
            idle_pct = (rnd_sent < RANDOM_ITEMS / 3) ? 27 :
                       (rnd_sent < 2 * RANDOM_ITEMS / 3) ? 77 : 0;
            roll     = $urandom_range(0, 99);
            pick_idx = POS_W'($urandom_range(0, 63));
            pick_val = pick_value();
            if (roll < 45) begin
               issue_req(KIND_INSERT, pick_val, pick_idx, 1'b0, '0);
            end else if (roll < 60) begin
               if (shadow_len > 0 && $urandom_range(0, 99) < 70)
                  pick_val = shadow_desc ?
                     shadow_vals[shadow_len-1] - $signed($urandom_range(0, 50)) :
                     shadow_vals[shadow_len-1] + $signed($urandom_range(0, 50));
               issue_req(KIND_APPEND, pick_val, pick_idx, 1'b0, '0);
            end else if (roll < 95) begin
               if (shadow_len > 0 && $urandom_range(0, 99) < 80)
                  pick_idx = POS_W'($urandom_range(0, shadow_len - 1));
               issue_req(KIND_READ, pick_val, pick_idx, 1'b0, '0);
            end else begin
               issue_req(KIND_CLEAR, pick_val, pick_idx, 1'b0, '0);
            end
            rnd_sent++;
         end
      end

      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fault_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule

### sim.f
rtl/core/sli_pkg.sv
rtl/core/sli_ctrl.sv
rtl/core/sli_datapath.sv
rtl/core/sorted_list_insert.sv
verif/tb.sv
